@@ design/scfs_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// scfs_pkg: shared types, constants and tables of the sound frame sequencer
// Holds the sequencer state record, the opcodes and the length and noise
// period lookup tables.
// ----------------------------------------------------------------------------
package scfs_pkg;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_TICK  = 1'b1;

	localparam logic [5:0] VOL_STEP = 6'd3;
	localparam logic [5:0] VOL_FULL = 6'd45;
	localparam logic [5:0] FADE_OFF = 6'h3f;
	localparam logic [4:0] SWEEP_OFF = 5'h1f;
	localparam logic [8:0] LEN_INF = 9'h100;
	localparam logic [7:0] LIN_INF = 8'h80;
	localparam logic [11:0] SWEEP_LOW = 12'h008;
	localparam logic [11:0] SWEEP_HIGH = 12'h3ff;

	// Full architectural state of the sequencer.
	typedef struct packed {
		logic [15:0][7:0] regs;
		logic [3:0][5:0]  volume;
		logic [2:0][10:0] period;
		logic [9:0]       noise_per;
		logic [3:0][5:0]  fade_rel;
		logic [3:0][5:0]  fade_cnt;
		logic [3:0][8:0]  len_cnt;
		logic [7:0]       lin_cnt;
		logic [1:0][4:0]  sw_rel;
		logic [1:0][4:0]  sw_cnt;
		logic [1:0][2:0]  sw_shift;
		logic [1:0]       sw_neg;
		logic [3:0]       status;
		logic [1:0]       phase;
	} state_t;

	function automatic logic [8:0] len_lookup(input logic [4:0] idx);
		logic [7:0] v;
		case (idx)
			5'd0: v = 8'd9;    5'd1: v = 8'd253; 5'd2: v = 8'd19;  5'd3: v = 8'd1;
			5'd4: v = 8'd39;   5'd5: v = 8'd3;   5'd6: v = 8'd79;  5'd7: v = 8'd5;
			5'd8: v = 8'd159;  5'd9: v = 8'd7;   5'd10: v = 8'd59; 5'd11: v = 8'd9;
			5'd12: v = 8'd13;  5'd13: v = 8'd11; 5'd14: v = 8'd25; 5'd15: v = 8'd13;
			5'd16: v = 8'd11;  5'd17: v = 8'd15; 5'd18: v = 8'd23; 5'd19: v = 8'd17;
			5'd20: v = 8'd47;  5'd21: v = 8'd19; 5'd22: v = 8'd95; 5'd23: v = 8'd21;
			5'd24: v = 8'd191; 5'd25: v = 8'd23; 5'd26: v = 8'd71; 5'd27: v = 8'd25;
			5'd28: v = 8'd15;  5'd29: v = 8'd27; 5'd30: v = 8'd31; 5'd31: v = 8'd29;
			default: v = 8'd0;
		endcase
		return {1'b0, v};
	endfunction

	function automatic logic [9:0] noise_lookup(input logic [3:0] idx);
		logic [9:0] v;
		case (idx)
			4'd0: v = 10'd1;    4'd1: v = 10'd2;    4'd2: v = 10'd4;    4'd3: v = 10'd8;
			4'd4: v = 10'd16;   4'd5: v = 10'd24;   4'd6: v = 10'd32;   4'd7: v = 10'd40;
			4'd8: v = 10'd64;   4'd9: v = 10'd96;   4'd10: v = 10'd128; 4'd11: v = 10'd192;
			4'd12: v = 10'd256; 4'd13: v = 10'd384; 4'd14: v = 10'd512; 4'd15: v = 10'd512;
			default: v = 10'd1;
		endcase
		return v;
	endfunction

endpackage
`default_nettype wire

@@ design/scfs_write.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// scfs_write: register write decode
// Stores the byte and derives the channel loads and the start mask.
// ----------------------------------------------------------------------------
module scfs_write (
	input  var scfs_pkg::state_t cur,
	input  wire [3:0]            addr,
	input  wire [7:0]            data,
	output scfs_pkg::state_t     nxt,
	output logic [3:0]           start
);
	logic [1:0] ch;
	logic [1:0] idx;
	logic [7:0] r0;
	logic [7:0] r1;
	logic [7:0] r2;
	logic [7:0] r3;
	logic [5:0] vol;
	logic [5:0] fade;
	logic [8:0] len;
	logic [10:0] per;

	// Decode the addressed channel with the new byte in place.
	always_comb begin
		nxt = cur;
		nxt.regs[addr] = data;
		ch = addr[3:2];
		idx = addr[1:0];
		r0 = nxt.regs[{ch, 2'd0}];
		r1 = nxt.regs[{ch, 2'd1}];
		r2 = nxt.regs[{ch, 2'd2}];
		r3 = nxt.regs[{ch, 2'd3}];
		vol = r0[4] ? ({1'b0, r0[3:0], 1'b0} + {2'b0, r0[3:0]}) : scfs_pkg::VOL_FULL;
		fade = r0[4] ? scfs_pkg::FADE_OFF : 6'({2'b0, r0[3:0]} + 6'd1);
		len = r0[5] ? scfs_pkg::LEN_INF : scfs_pkg::len_lookup(r3[7:3]);
		per = {r3[2:0], r2};
		start = 4'd0;
		case (ch)
			2'd0, 2'd1: begin
				case (idx)
					2'd0: begin
						nxt.volume[ch] = vol;
						nxt.fade_rel[ch] = fade;
						nxt.fade_cnt[ch] = fade;
					end
					2'd1: begin
						nxt.sw_rel[ch[0]] = r1[7] ? 5'({2'b0, r1[6:4]} + 5'd1)
							: scfs_pkg::SWEEP_OFF;
						nxt.sw_cnt[ch[0]] = nxt.sw_rel[ch[0]];
						nxt.sw_shift[ch[0]] = r1[2:0];
						nxt.sw_neg[ch[0]] = r1[3];
					end
					2'd2: nxt.period[ch] = per;
					default: begin
						nxt.len_cnt[ch] = len;
						nxt.period[ch] = per;
						nxt.volume[ch] = vol;
						nxt.status[ch] = 1'b1;
						nxt.fade_rel[ch] = fade;
						nxt.fade_cnt[ch] = fade;
						start[ch] = 1'b1;
					end
				endcase
			end
			2'd2: begin
				if (idx == 2'd2) begin
					nxt.period[2] = per;
				end else if (idx == 2'd3) begin
					if (r0[7]) begin
						nxt.len_cnt[2] = scfs_pkg::LEN_INF;
						nxt.lin_cnt = scfs_pkg::LIN_INF;
					end else if (r0[6:0] != 7'd0) begin
						nxt.len_cnt[2] = scfs_pkg::len_lookup(r3[7:3]);
						nxt.lin_cnt = {1'b0, r0[6:0]};
						nxt.volume[2] = scfs_pkg::VOL_FULL;
					end else begin
						nxt.len_cnt[2] = scfs_pkg::LEN_INF;
						nxt.lin_cnt = scfs_pkg::LIN_INF;
						nxt.volume[2] = 6'd0;
					end
					nxt.period[2] = per;
					nxt.status[2] = 1'b1;
					nxt.fade_rel[2] = scfs_pkg::FADE_OFF;
					nxt.fade_cnt[2] = scfs_pkg::FADE_OFF;
					start[2] = 1'b1;
				end
			end
			default: begin
				case (idx)
					2'd0: begin
						nxt.volume[3] = vol;
						nxt.fade_rel[3] = fade;
						nxt.fade_cnt[3] = fade;
					end
					2'd2: begin
						nxt.noise_per = scfs_pkg::noise_lookup(r2[3:0]);
						nxt.volume[3] = vol;
					end
					2'd3: begin
						nxt.len_cnt[3] = len;
						nxt.volume[3] = vol;
						nxt.noise_per = scfs_pkg::noise_lookup(r2[3:0]);
						nxt.status[3] = 1'b1;
						nxt.fade_rel[3] = fade;
						nxt.fade_cnt[3] = fade;
						start[3] = 1'b1;
					end
					default: ;
				endcase
			end
		endcase
	end

endmodule
`default_nettype wire

@@ design/scfs_tick.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// scfs_tick: frame tick update
// Fades volumes, runs the linear count, the sweeps and the length counters.
// ----------------------------------------------------------------------------
module scfs_tick (
	input  var scfs_pkg::state_t cur,
	output scfs_pkg::state_t     nxt
);
	logic [5:0] fc;
	logic [10:0] dlt;
	logic [11:0] p;
	logic [8:0] lc;

	always_comb begin
		nxt = cur;
		fc = '0;
		dlt = '0;
		p = '0;
		lc = '0;
		// Volume fade for every channel.
		for (int i = 0; i < 4; i++) begin
			fc = cur.fade_cnt[i];
			if (fc != scfs_pkg::FADE_OFF && fc != 6'd0) begin
				fc = fc - 6'd1;
				nxt.fade_cnt[i] = fc;
				if (fc == 6'd0) begin
					nxt.fade_cnt[i] = cur.fade_rel[i];
					if (cur.volume[i] > scfs_pkg::VOL_STEP) begin
						nxt.volume[i] = cur.volume[i] - scfs_pkg::VOL_STEP;
					end else if (cur.len_cnt[i][8]) begin
						nxt.volume[i] = scfs_pkg::VOL_FULL;
					end else begin
						nxt.volume[i] = 6'd0;
						nxt.status[i] = 1'b0;
					end
				end
			end else if (fc == 6'd0) begin
				nxt.volume[i] = 6'd0;
				nxt.status[i] = 1'b0;
			end
		end
		// Triangle linear count on phase one.
		if (cur.phase == 2'd1 && !cur.lin_cnt[7] && cur.lin_cnt != 8'd0) begin
			nxt.lin_cnt = cur.lin_cnt - 8'd1;
			if (nxt.lin_cnt == 8'd0) begin
				nxt.status[2] = 1'b0;
			end
		end
		// Sweeps and length counters on phase three.
		if (cur.phase == 2'd3) begin
			for (int i = 0; i < 2; i++) begin
				if (cur.sw_cnt[i] != scfs_pkg::SWEEP_OFF && cur.sw_cnt[i] != 5'd0) begin
					nxt.sw_cnt[i] = cur.sw_cnt[i] - 5'd1;
					if (nxt.sw_cnt[i] == 5'd0) begin
						nxt.sw_cnt[i] = cur.sw_rel[i];
						p = {1'b0, cur.period[i]};
						dlt = cur.period[i] >> cur.sw_shift[i];
						if (cur.sw_shift[i] != 3'd0) begin
							if (cur.sw_neg[i]) begin
								p = p - {1'b0, dlt} - ((i == 0) ? 12'd1 : 12'd0);
							end else begin
								p = p + {1'b0, dlt};
							end
						end
						// p wraps negative to a large value, which fails the range check.
						if (p > scfs_pkg::SWEEP_LOW && p < scfs_pkg::SWEEP_HIGH) begin
							nxt.period[i] = p[10:0];
						end else begin
							nxt.status[i] = 1'b0;
						end
					end
				end
			end
			for (int i = 0; i < 4; i++) begin
				lc = cur.len_cnt[i];
				if (!lc[8] && lc != 9'd0) begin
					lc = lc - 9'd1;
					nxt.len_cnt[i] = lc;
					if (lc == 9'd0) begin
						nxt.status[i] = 1'b0;
					end
				end
			end
		end
		nxt.phase = cur.phase + 2'd1;
	end

endmodule
`default_nettype wire

@@ design/sound_channel_frame_sequencer.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sound_channel_frame_sequencer: four-channel sound frame sequencer
// Applies register writes and frame ticks to the channel state and reports
// the updated state with start and stop masks for each item.
// ----------------------------------------------------------------------------
// The result of an input transfer is in the output register in the cycle after the transfer.
// Throughput: one item per cycle while the output is taken; the state register updates at the input transfer.
// The output register is refilled while its result is being taken.
// Reset clears all state, with the noise period at one, and empties the output.
module sound_channel_frame_sequencer (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        in_valid,
	output logic       in_ready,
	input  wire        opcode,
	input  wire [3:0]  reg_addr,
	input  wire [7:0]  write_data,
	output logic       out_valid,
	input  wire        out_ready,
	output logic [3:0] active_mask,
	output logic [5:0] sq0_volume,
	output logic [5:0] sq1_volume,
	output logic [5:0] tri_volume,
	output logic [5:0] noise_volume,
	output logic [10:0] sq0_period,
	output logic [10:0] sq1_period,
	output logic [10:0] tri_period,
	output logic [9:0] noise_period,
	output logic [3:0] duty_pair,
	output logic [3:0] start_mask,
	output logic [3:0] stop_mask
);
	// State after reset: everything cleared except the noise period.
	localparam scfs_pkg::state_t ST_RESET = '{noise_per: 10'd1, default: '0};

	scfs_pkg::state_t st_q;
	scfs_pkg::state_t wr_nxt;
	scfs_pkg::state_t tk_nxt;
	scfs_pkg::state_t nxt;
	logic [3:0] wr_start;
	logic       take;

	scfs_write u_write (.cur(st_q), .addr(reg_addr), .data(write_data),
		.nxt(wr_nxt), .start(wr_start));
	scfs_tick u_tick (.cur(st_q), .nxt(tk_nxt));

	assign nxt = (opcode == scfs_pkg::OP_TICK) ? tk_nxt : wr_nxt;
	assign in_ready = !out_valid || out_ready;
	assign take = in_valid && in_ready;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_RESET;
		end else if (take) begin
			st_q <= nxt;
		end
	end

	// Output valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (in_ready) begin
			out_valid <= in_valid;
		end
	end

	// Result register.
	always_ff @(posedge clk) begin
		if (take) begin
			active_mask <= nxt.status;
			sq0_volume <= nxt.volume[0];
			sq1_volume <= nxt.volume[1];
			tri_volume <= nxt.volume[2];
			noise_volume <= nxt.volume[3];
			sq0_period <= nxt.period[0];
			sq1_period <= nxt.period[1];
			tri_period <= nxt.period[2];
			noise_period <= nxt.noise_per;
			duty_pair <= {nxt.regs[4][7:6], nxt.regs[0][7:6]};
			start_mask <= (opcode == scfs_pkg::OP_TICK) ? 4'd0 : wr_start;
			stop_mask <= st_q.status & ~nxt.status;
		end
	end

	// A channel cannot be started and stopped by one item.
	a_start_stop: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (start_mask & stop_mask) == 4'd0)
		else $error("start and stop overlap");
	// A started channel is reported active.
	a_start_active: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (start_mask & ~active_mask) == 4'd0)
		else $error("started channel not active");
	// A held result does not change.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> $stable(active_mask) && $stable(st_q))
		else $error("result changed while stalled");

endmodule
`default_nettype wire

@@ test/scfs_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// scfs_checker: prediction and comparison for the sound frame sequencer
// Watches the input and output channels, keeps its own copy of the channel
// state, works out the expected result of every input transfer and compares
// each output transfer with the oldest expected result.
// ----------------------------------------------------------------------------
module scfs_checker (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        in_valid,
	input  wire        in_ready,
	input  wire        opcode,
	input  wire [3:0]  reg_addr,
	input  wire [7:0]  write_data,
	input  wire        out_valid,
	input  wire        out_ready,
	input  wire [3:0]  active_mask,
	input  wire [5:0]  sq0_volume,
	input  wire [5:0]  sq1_volume,
	input  wire [5:0]  tri_volume,
	input  wire [5:0]  noise_volume,
	input  wire [10:0] sq0_period,
	input  wire [10:0] sq1_period,
	input  wire [10:0] tri_period,
	input  wire [9:0]  noise_period,
	input  wire [3:0]  duty_pair,
	input  wire [3:0]  start_mask,
	input  wire [3:0]  stop_mask,
	output int         fail_count,
	output int         pending_count,
	output int         frame_count
);

	typedef struct packed {
		logic [3:0]  active;
		logic [3:0][5:0] vol;
		logic [2:0][10:0] per;
		logic [9:0]  nper;
		logic [3:0]  duty;
		logic [3:0]  started;
		logic [3:0]  stopped;
	} frame_t;

	// Channel state mirror.
	logic [7:0]  regs [16];
	logic [5:0]  vol [4];
	logic [10:0] per [3];
	logic [9:0]  nper;
	logic [5:0]  fade_rel [4];
	logic [5:0]  fade_cnt [4];
	logic [8:0]  len_cnt [4];
	logic [7:0]  lin_cnt;
	logic [4:0]  sw_rel [2];
	logic [4:0]  sw_cnt [2];
	logic [2:0]  sw_shift [2];
	logic        sw_neg [2];
	logic [3:0]  status;
	logic [1:0]  phase;

	frame_t expected_frames [$];

	function automatic logic [8:0] length_code(input logic [4:0] i);
		logic [7:0] t [32] = '{9, 253, 19, 1, 39, 3, 79, 5, 159, 7, 59, 9, 13, 11, 25, 13,
			11, 15, 23, 17, 47, 19, 95, 21, 191, 23, 71, 25, 15, 27, 31, 29};
		return {1'b0, t[i]};
	endfunction

	function automatic logic [9:0] noise_code(input logic [3:0] i);
		logic [9:0] t [16] = '{1, 2, 4, 8, 16, 24, 32, 40, 64, 96, 128, 192, 256, 384,
			512, 512};
		return t[i];
	endfunction

	function automatic logic [5:0] level_of(input logic [7:0] r0);
		return r0[4] ? 6'(r0[3:0] * 3) : scfs_pkg::VOL_FULL;
	endfunction

	function automatic void arm_fade(input int ch, input logic [7:0] r0);
		logic [5:0] f;
		f = r0[4] ? scfs_pkg::FADE_OFF : 6'(r0[3:0] + 1);
		fade_rel[ch] = f;
		fade_cnt[ch] = f;
	endfunction

	function automatic logic [10:0] period_from(input int b);
		return {regs[b + 3][2:0], regs[b + 2]};
	endfunction

	function automatic void reset_state();
		for (int i = 0; i < 16; i++) regs[i] = '0;
		for (int i = 0; i < 4; i++) begin
			vol[i] = '0; fade_rel[i] = '0; fade_cnt[i] = '0; len_cnt[i] = '0;
		end
		for (int i = 0; i < 3; i++) per[i] = '0;
		for (int i = 0; i < 2; i++) begin
			sw_rel[i] = '0; sw_cnt[i] = '0; sw_shift[i] = '0; sw_neg[i] = 1'b0;
		end
		nper = 10'd1; lin_cnt = '0; status = '0; phase = '0;
	endfunction

	// Register write: store the byte, then apply its channel action.
	function automatic logic [3:0] apply_write(input logic [3:0] a, input logic [7:0] d);
		int ch, idx, b;
		logic [7:0] r0, r1;
		logic [4:0] sv;
		ch = a[3:2]; idx = a[1:0]; b = ch * 4;
		regs[a] = d;
		r0 = regs[b]; r1 = regs[b + 1];
		if (ch <= 1) begin
			case (idx)
				0: begin
					vol[ch] = level_of(r0);
					arm_fade(ch, r0);
				end
				1: begin
					sv = r1[7] ? 5'(r1[6:4] + 1) : scfs_pkg::SWEEP_OFF;
					sw_rel[ch] = sv; sw_cnt[ch] = sv;
					sw_shift[ch] = r1[2:0]; sw_neg[ch] = r1[3];
				end
				2: per[ch] = period_from(b);
				default: begin
					len_cnt[ch] = r0[5] ? scfs_pkg::LEN_INF : length_code(regs[b + 3][7:3]);
					per[ch] = period_from(b);
					vol[ch] = level_of(r0);
					status[ch] = 1'b1;
					arm_fade(ch, r0);
					return 4'(1 << ch);
				end
			endcase
		end else if (ch == 2) begin
			if (idx == 2) per[2] = period_from(b);
			else if (idx == 3) begin
				if (r0[7]) begin
					len_cnt[2] = scfs_pkg::LEN_INF; lin_cnt = scfs_pkg::LIN_INF;
				end else if (r0[6:0] != 0) begin
					len_cnt[2] = length_code(regs[b + 3][7:3]);
					lin_cnt = {1'b0, r0[6:0]};
					vol[2] = scfs_pkg::VOL_FULL;
				end else begin
					len_cnt[2] = scfs_pkg::LEN_INF; lin_cnt = scfs_pkg::LIN_INF; vol[2] = '0;
				end
				per[2] = period_from(b);
				status[2] = 1'b1;
				fade_rel[2] = scfs_pkg::FADE_OFF; fade_cnt[2] = scfs_pkg::FADE_OFF;
				return 4'b0100;
			end
		end else begin
			if (idx == 0) begin
				vol[3] = level_of(r0);
				arm_fade(3, r0);
			end else if (idx == 2) begin
				nper = noise_code(regs[b + 2][3:0]);
				vol[3] = level_of(r0);
			end else if (idx == 3) begin
				len_cnt[3] = r0[5] ? scfs_pkg::LEN_INF : length_code(regs[b + 3][7:3]);
				vol[3] = level_of(r0);
				nper = noise_code(regs[b + 2][3:0]);
				status[3] = 1'b1;
				arm_fade(3, r0);
				return 4'b1000;
			end
		end
		return 4'b0000;
	endfunction

	// Frame tick: fades, triangle linear count, sweeps and length counters.
	function automatic void apply_tick();
		int p, dlt;
		for (int i = 0; i < 4; i++) begin
			if (fade_cnt[i] != scfs_pkg::FADE_OFF && fade_cnt[i] > 0) begin
				fade_cnt[i] = fade_cnt[i] - 1;
				if (fade_cnt[i] == 0) begin
					fade_cnt[i] = fade_rel[i];
					if (int'(vol[i]) - 3 > 0) vol[i] = vol[i] - 3;
					else if (len_cnt[i][8]) vol[i] = scfs_pkg::VOL_FULL;
					else begin
						vol[i] = '0; status[i] = 1'b0;
					end
				end
			end else if (fade_cnt[i] == 0) begin
				vol[i] = '0; status[i] = 1'b0;
			end
		end
		if (phase == 1 && !lin_cnt[7] && lin_cnt > 0) begin
			lin_cnt = lin_cnt - 1;
			if (lin_cnt == 0) status[2] = 1'b0;
		end
		if (phase == 3) begin
			for (int i = 0; i < 2; i++) begin
				if (sw_cnt[i] != scfs_pkg::SWEEP_OFF && sw_cnt[i] > 0) begin
					sw_cnt[i] = sw_cnt[i] - 1;
					if (sw_cnt[i] == 0) begin
						sw_cnt[i] = sw_rel[i];
						p = per[i];
						if (sw_shift[i] != 0) begin
							dlt = p >> sw_shift[i];
							if (sw_neg[i]) p = (i == 0) ? p - dlt - 1 : p - dlt;
							else p = p + dlt;
						end
						if (p > 8 && p < 'h3ff) per[i] = 11'(p);
						else status[i] = 1'b0;
					end
				end
			end
			for (int i = 0; i < 4; i++) begin
				if (!len_cnt[i][8] && len_cnt[i] > 0) begin
					len_cnt[i] = len_cnt[i] - 1;
					if (len_cnt[i] == 0) status[i] = 1'b0;
				end
			end
		end
		phase = phase + 1;
	endfunction

	function automatic frame_t predict_frame(input logic op, input logic [3:0] a,
		input logic [7:0] d);
		frame_t f;
		logic [3:0] prior;
		prior = status;
		f.started = '0;
		if (op == scfs_pkg::OP_TICK) apply_tick();
		else f.started = apply_write(a, d);
		f.active = status;
		for (int i = 0; i < 4; i++) f.vol[i] = vol[i];
		for (int i = 0; i < 3; i++) f.per[i] = per[i];
		f.nper = nper;
		f.duty = {regs[4][7:6], regs[0][7:6]};
		f.stopped = prior & ~status;
		return f;
	endfunction

	task automatic check_field(input string name, input int exp_v, input int act_v);
		if (exp_v != act_v) begin
			$error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
			fail_count++;
		end
	endtask

	initial reset_state();
	assign pending_count = expected_frames.size();

	always @(posedge clk or negedge arst_n) begin
		frame_t e;
		if (!arst_n) begin
			reset_state();
			expected_frames.delete();
			fail_count <= 0;
			frame_count <= 0;
		end else begin
			// Compare the output transfer first; it never belongs to this cycle's input.
			if (out_valid && out_ready) begin
				frame_count <= frame_count + 1;
				if (expected_frames.size() == 0) begin
					$error("output transfer with no expected result");
					fail_count++;
				end else begin
					e = expected_frames.pop_front();
					check_field("active_mask", e.active, active_mask);
					check_field("sq0_volume", e.vol[0], sq0_volume);
					check_field("sq1_volume", e.vol[1], sq1_volume);
					check_field("tri_volume", e.vol[2], tri_volume);
					check_field("noise_volume", e.vol[3], noise_volume);
					check_field("sq0_period", e.per[0], sq0_period);
					check_field("sq1_period", e.per[1], sq1_period);
					check_field("tri_period", e.per[2], tri_period);
					check_field("noise_period", e.nper, noise_period);
					check_field("duty_pair", e.duty, duty_pair);
					check_field("start_mask", e.started, start_mask);
					check_field("stop_mask", e.stopped, stop_mask);
				end
			end
			if (in_valid && in_ready)
				expected_frames.push_back(predict_frame(opcode, reg_addr, write_data));
		end
	end

endmodule

@@ test/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: stimulus and verdict for the sound frame sequencer
// Drives directed and random register writes and frame ticks through the
// input channel under several idling phases; the checker does the scoring.
// ----------------------------------------------------------------------------
module tb;

	localparam int WATCHDOG_LIMIT = 5000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic        opcode = scfs_pkg::OP_WRITE;
	logic [3:0]  reg_addr = '0;
	logic [7:0]  write_data = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [3:0]  active_mask, duty_pair, start_mask, stop_mask;
	logic [5:0]  sq0_volume, sq1_volume, tri_volume, noise_volume;
	logic [10:0] sq0_period, sq1_period, tri_period;
	logic [9:0]  noise_period;
	int          fail_count, pending_count, frame_count;
	int          send_idle_pct = 0, recv_stall_pct = 0;
	int          idle_cycles = 0;
	int          writes_sent = 0, ticks_sent = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	sound_channel_frame_sequencer dut (.*);

	scfs_checker checker_i (.*);

	// Receiver stalls at random.
	always @(posedge clk)
		out_ready <= ($urandom_range(99) >= recv_stall_pct);

	// Watchdog on cycles with no transfer on either channel.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// Present one item, hold it until transferred, then idle at random.
	task automatic send_item(input logic op, input logic [3:0] a, input logic [7:0] d);
		opcode <= op;
		reg_addr <= a;
		write_data <= d;
		in_valid <= 1'b1;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		if (op == scfs_pkg::OP_TICK) ticks_sent++;
		else writes_sent++;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_count != 0) @(posedge clk);
	endtask

	// A channel program: set up its registers, start it, then tick a while.
	task automatic play_channel();
		int ch, n;
		ch = $urandom_range(3);
		for (int r = 0; r < 3; r++)
			if ($urandom_range(3) != 0)
				send_item(scfs_pkg::OP_WRITE, 4'(ch * 4 + r), 8'($urandom));
		send_item(scfs_pkg::OP_WRITE, 4'(ch * 4 + 3), 8'($urandom));
		n = $urandom_range(12);
		for (int k = 0; k < n; k++)
			send_item(scfs_pkg::OP_TICK, 4'($urandom), 8'($urandom));
	endtask

	initial begin
		int phase_pct [4][2] = '{'{0, 0}, '{58, 0}, '{0, 58}, '{6, 6}};
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: reset state, extremes, every register, special cases.
		send_item(scfs_pkg::OP_TICK, 4'hf, 8'hff);
		for (int a = 0; a < 16; a++) send_item(scfs_pkg::OP_WRITE, 4'(a), 8'hff);
		send_item(scfs_pkg::OP_WRITE, 4'h8, 8'h00);
		send_item(scfs_pkg::OP_WRITE, 4'hb, 8'h00);
		send_item(scfs_pkg::OP_WRITE, 4'h8, 8'h01);
		send_item(scfs_pkg::OP_WRITE, 4'hb, 8'h08);
		for (int k = 0; k < 4; k++) send_item(scfs_pkg::OP_TICK, 4'h0, 8'h00);
		// Fast downward sweep set up and started on square 0, with no ticks before the drain.
		send_item(scfs_pkg::OP_WRITE, 4'h1, 8'h89);
		send_item(scfs_pkg::OP_WRITE, 4'h3, 8'h00);
		drain();
		send_item(scfs_pkg::OP_WRITE, 4'h0, 8'h00);

		// Random phases; mostly channel programs, some raw noise.
		for (int ph = 0; ph < 4; ph++) begin
			send_idle_pct = phase_pct[ph][0];
			recv_stall_pct = phase_pct[ph][1];
			while (writes_sent + ticks_sent < 40 + (ph + 1) * 360) begin
				if ($urandom_range(9) < 7) play_channel();
				else send_item(1'($urandom_range(1)), 4'($urandom), 8'($urandom));
			end
			drain();
		end

		recv_stall_pct = 0;
		drain();
		repeat (5) @(posedge clk);
		$display("Covered %0d register writes and %0d frame ticks, %0d results checked.",
			writes_sent, ticks_sent, frame_count);
		if (fail_count == 0 && pending_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
